>>> rtl/astk_pkg.sv
// Shared constants, codes and types for the array stack with search.
// Used by astk_mem, astk_ctrl and array_stack_with_search.
`timescale 1ns / 1ps
`default_nettype none
package astk_pkg;

    localparam int DEPTH = 128;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int VAL_W = 32;
    localparam int KIND_W = 2;
    localparam int STAT_W = 2;
    localparam int IDX_W = 7;

    localparam logic [KIND_W-1:0] KIND_PUSH   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_POP    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_PEEK   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_SEARCH = 2'd3;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;
    localparam logic [STAT_W-1:0] STAT_NONE  = 2'd3;

    typedef struct packed {
        logic             we;
        logic [PTR_W-1:0] waddr;
        logic [VAL_W-1:0] wdata;
        logic [PTR_W-1:0] raddr;
    } t_mem_req;

endpackage
`default_nettype wire

>>> rtl/astk_mem.sv
// Stack storage: one write port, one read port with registered read data.
// Depends on astk_pkg.
`timescale 1ns / 1ps
`default_nettype none
module astk_mem (
    input  wire                            i_clk,
    input  wire  astk_pkg::t_mem_req       i_req,
    output logic [astk_pkg::VAL_W-1:0]     o_rdata
);
    import astk_pkg::*;

    logic [VAL_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_req.raddr];
    end

endmodule
`default_nettype wire

>>> rtl/astk_ctrl.sv
// Sequencer: fill count, operation decode, search walk over the shared
// compare unit, and the result word register. Depends on astk_pkg.
`timescale 1ns / 1ps
`default_nettype none
module astk_ctrl (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_in_valid,
    output logic                            o_in_ready,
    input  wire  [astk_pkg::KIND_W-1:0]     i_kind,
    input  wire  [astk_pkg::VAL_W-1:0]      i_value,
    output logic                            o_out_valid,
    input  wire                             i_out_ready,
    output logic [astk_pkg::STAT_W-1:0]     o_status,
    output logic [astk_pkg::VAL_W-1:0]      o_data,
    output logic [astk_pkg::IDX_W-1:0]      o_found_index,
    output astk_pkg::t_mem_req              o_req,
    input  wire  [astk_pkg::VAL_W-1:0]      i_rdata
);
    import astk_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_SRCH = 2'd2;

    logic [1:0]        r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [PTR_W-1:0]  r_ptr, n_ptr;
    logic [VAL_W-1:0]  r_key, n_key;
    logic              r_out_valid, n_out_valid;
    logic [STAT_W-1:0] r_status, n_status;
    logic [VAL_W-1:0]  r_data, n_data;
    logic [IDX_W-1:0]  r_fidx, n_fidx;
    logic              accept;
    logic              full;
    logic              empty;
    logic              match;
    logic [PTR_W-1:0]  top_ptr;

    assign o_in_ready    = (r_state == S_IDLE) && !r_out_valid;
    assign accept        = i_in_valid && o_in_ready;
    assign full          = (r_count == CNT_W'(DEPTH));
    assign empty         = (r_count == '0);
    assign top_ptr       = r_count[PTR_W-1:0] - PTR_W'(1);
    assign match         = (i_rdata == r_key);
    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_data        = r_data;
    assign o_found_index = r_fidx;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_ptr       = r_ptr;
        n_key       = r_key;
        n_out_valid = r_out_valid;
        n_status    = r_status;
        n_data      = r_data;
        n_fidx      = r_fidx;
        o_req.we    = 1'b0;
        o_req.waddr = r_count[PTR_W-1:0];
        o_req.wdata = i_value;
        o_req.raddr = (r_state == S_SRCH) ? (r_ptr - PTR_W'(1)) : top_ptr;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_data = '0;
                    n_fidx = '0;
                    case (i_kind)
                        KIND_PUSH: begin
                            n_out_valid = 1'b1;
                            if (full) begin
                                n_status = STAT_FULL;
                            end else begin
                                o_req.we = 1'b1;
                                n_count  = r_count + CNT_W'(1);
                                n_status = STAT_OK;
                            end
                        end
                        KIND_POP, KIND_PEEK: begin
                            if (empty) begin
                                n_out_valid = 1'b1;
                                n_status    = STAT_EMPTY;
                            end else begin
                                n_state = S_READ;
                                if (i_kind == KIND_POP) begin
                                    n_count = r_count - CNT_W'(1);
                                end
                            end
                        end
                        default: begin
                            if (empty) begin
                                n_out_valid = 1'b1;
                                n_status    = STAT_EMPTY;
                            end else begin
                                n_state = S_SRCH;
                                n_ptr   = top_ptr;
                                n_key   = i_value;
                            end
                        end
                    endcase
                end
            end
            S_READ: begin
                n_out_valid = 1'b1;
                n_status    = STAT_OK;
                n_data      = i_rdata;
                n_state     = S_IDLE;
            end
            S_SRCH: begin
                // read data holds the entry at r_ptr
                if (match) begin
                    n_out_valid = 1'b1;
                    n_status    = STAT_OK;
                    n_fidx      = IDX_W'(r_ptr);
                    n_state     = S_IDLE;
                end else if (r_ptr == '0) begin
                    n_out_valid = 1'b1;
                    n_status    = STAT_NONE;
                    n_state     = S_IDLE;
                end else begin
                    n_ptr = r_ptr - PTR_W'(1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptr    <= n_ptr;
        r_key    <= n_key;
        r_status <= n_status;
        r_data   <= n_data;
        r_fidx   <= n_fidx;
    end

endmodule
`default_nettype wire

>>> rtl/array_stack_with_search.sv
// Array stack with search: push, pop, peek and top-down search.
// Result path: push and any full or empty report load the result register
// at accept; pop and peek go via the registered memory read and S_READ;
// search compares entries top down, one compare per cycle, up to DEPTH.
// One word in flight: next input is taken the cycle after the result is taken.
// Reset: stack empty, no result pending; storage contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none
module array_stack_with_search (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_in_valid,
    output logic                                  o_in_ready,
    input  wire         [astk_pkg::KIND_W-1:0]    i_kind,
    input  wire  signed [astk_pkg::VAL_W-1:0]     i_value,
    output logic                                  o_out_valid,
    input  wire                                   i_out_ready,
    output logic        [astk_pkg::STAT_W-1:0]    o_status,
    output logic signed [astk_pkg::VAL_W-1:0]     o_data,
    output logic        [astk_pkg::IDX_W-1:0]     o_found_index
);
    import astk_pkg::*;

    t_mem_req         mem_req;
    logic [VAL_W-1:0] mem_rdata;
    logic [VAL_W-1:0] data_bits;

    assign o_data = data_bits;

    astk_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_kind        (i_kind),
        .i_value       (i_value),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_status      (o_status),
        .o_data        (data_bits),
        .o_found_index (o_found_index),
        .o_req         (mem_req),
        .i_rdata       (mem_rdata)
    );

    astk_mem u_mem (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

    a_accept_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input taken while previous word in flight");

    a_out_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && !(i_in_valid && o_in_ready)) |=> !o_out_valid)
        else $error("result word repeated");

    a_data_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_data != '0 || o_found_index != '0)) |-> (o_status == STAT_OK))
        else $error("nonzero payload on error status");

    a_push_result_fast: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_kind == KIND_PUSH) |=>
        (o_out_valid && (o_status == STAT_OK || o_status == STAT_FULL)))
        else $error("push result missing");

endmodule
`default_nettype wire

>>> tb/tb_array_stack_with_search.sv
// Self-checking testbench for array_stack_with_search: push, pop, peek and search words
// are checked against a queue-based shadow stack, with random gaps and stalls on both sides.
// Depends on astk_pkg and the array_stack_with_search RTL.
`timescale 1ns / 1ps
module tb_array_stack_with_search;
    import astk_pkg::*;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [VAL_W-1:0]  data;
        logic [IDX_W-1:0]  idx;
    } t_reply;

    class stack_shadow;
        logic [VAL_W-1:0] stored[$];
        t_reply           pending[$];
        int               errors;
        int               checked;
        int               n_kind[4];
        int               n_full;
        int               n_empty;
        int               n_none;
        int               n_hit;
        int               peak;

        function void note_word(logic [KIND_W-1:0] k, logic [VAL_W-1:0] v);
            t_reply r;
            int     i;
            r.status = STAT_OK;
            r.data   = '0;
            r.idx    = '0;
            n_kind[k]++;
            case (k)
                KIND_PUSH: begin
                    if (stored.size() >= DEPTH) r.status = STAT_FULL;
                    else stored.push_back(v);
                end
                KIND_POP: begin
                    if (stored.size() == 0) r.status = STAT_EMPTY;
                    else r.data = stored.pop_back();
                end
                KIND_PEEK: begin
                    if (stored.size() == 0) r.status = STAT_EMPTY;
                    else r.data = stored[stored.size() - 1];
                end
                default: begin
                    if (stored.size() == 0) begin
                        r.status = STAT_EMPTY;
                    end else begin
                        r.status = STAT_NONE;
                        for (i = stored.size() - 1; i >= 0 && r.status == STAT_NONE; i--)
                            if (stored[i] == v) begin
                                r.status = STAT_OK;
                                r.idx    = IDX_W'(i);
                            end
                    end
                end
            endcase
            case (r.status)
                STAT_FULL:  n_full++;
                STAT_EMPTY: n_empty++;
                STAT_NONE:  n_none++;
                default: if (k == KIND_SEARCH) n_hit++;
            endcase
            if (stored.size() > peak) peak = stored.size();
            pending.push_back(r);
        endfunction

        function void check_reply(logic [STAT_W-1:0] st, logic [VAL_W-1:0] d,
                                  logic [IDX_W-1:0] ix);
            t_reply e;
            checked++;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected word: status %0d data %h idx %0d", st, d, ix);
                return;
            end
            e = pending.pop_front();
            if (e.status !== st || e.data !== d || e.idx !== ix) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: exp status %0d data %h idx %0d, got status %0d data %h idx %0d",
                             e.status, e.data, e.idx, st, d, ix);
            end
        endfunction
    endclass

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_ready;
    logic [KIND_W-1:0]        i_kind = KIND_PUSH;
    logic signed [VAL_W-1:0]  i_value = '0;
    logic                     o_out_valid;
    logic                     i_out_ready = 1'b0;
    logic [STAT_W-1:0]        o_status;
    logic signed [VAL_W-1:0]  o_data;
    logic [IDX_W-1:0]         o_found_index;

    stack_shadow shadow;
    int          sent;
    bit          squeezed;

    array_stack_with_search dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_kind        (i_kind),
        .i_value       (i_value),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_status      (o_status),
        .o_data        (o_data),
        .o_found_index (o_found_index)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    initial begin
        #3_000_000;
        $display("tb_array_stack_with_search: errors");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [VAL_W-1:0] pick_value();
        logic [VAL_W-1:0] pool[8];
        pool = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                 32'h0000_0001, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_002A};
        if ($urandom_range(0, 9) < 4) return pool[$urandom_range(0, 7)];
        return $urandom;
    endfunction

    task automatic send_word(input logic [KIND_W-1:0] k, input logic [VAL_W-1:0] v);
        int gap;
        gap = ((sent / 60) % 4 == 3) ? 0 : pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_kind     <= k;
        i_value    <= v;
        do @(posedge i_clk); while (!o_in_ready);
        shadow.note_word(k, v);
        sent++;
    endtask

    // receiver: random stalls, quiet windows, and one long hold-off to back up the input
    initial begin : reply_side
        int hold;
        int cyc;
        hold = 0;
        cyc  = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            cyc++;
            if (o_out_valid && i_out_ready)
                shadow.check_reply(o_status, o_data, o_found_index);
            if (!squeezed && shadow.checked >= 240) begin
                squeezed = 1'b1;
                hold     = 400;
            end else if (hold == 0 && (cyc / 256) % 4 != 2 && $urandom_range(0, 3) == 0) begin
                hold = pick_gap();
            end
            if (hold > 0) begin
                i_out_ready <= 1'b0;
                hold--;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    initial begin
        logic [KIND_W-1:0] k;
        logic [VAL_W-1:0]  v;
        bit                filling;
        int                over;
        int                r;
        int                n;
        shadow   = new();
        sent     = 0;
        squeezed = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty reports, extremes, duplicates, top-down search order
        send_word(KIND_POP, 32'h1234_5678);
        send_word(KIND_PEEK, 32'hFFFF_FFFF);
        send_word(KIND_SEARCH, 32'h0000_0000);
        send_word(KIND_PUSH, 32'h7FFF_FFFF);
        send_word(KIND_PUSH, 32'h8000_0000);
        send_word(KIND_PUSH, 32'h0000_0000);
        send_word(KIND_PUSH, 32'hFFFF_FFFF);
        send_word(KIND_PUSH, 32'h7FFF_FFFF);
        send_word(KIND_PEEK, 32'h0000_0000);
        send_word(KIND_SEARCH, 32'h7FFF_FFFF);
        send_word(KIND_SEARCH, 32'h8000_0000);
        send_word(KIND_SEARCH, 32'h1234_5678);
        send_word(KIND_SEARCH, 32'hFFFF_FFFF);
        send_word(KIND_POP, 32'h0000_0000);
        send_word(KIND_POP, 32'h0000_0000);
        send_word(KIND_SEARCH, 32'h7FFF_FFFF);
        send_word(KIND_POP, 32'h0000_0000);
        send_word(KIND_POP, 32'h0000_0000);
        send_word(KIND_POP, 32'h0000_0000);
        send_word(KIND_POP, 32'h0000_0000);
        send_word(KIND_PUSH, 32'h5555_5555);
        send_word(KIND_PUSH, 32'hAAAA_AAAA);
        send_word(KIND_SEARCH, 32'h5555_5555);
        send_word(KIND_POP, 32'h0000_0000);
        send_word(KIND_POP, 32'h0000_0000);

        // random: alternate fill and drain phases so full and empty are both hit
        filling = 1'b1;
        over    = 0;
        for (n = 0; n < 730; n++) begin
            r = $urandom_range(0, 99);
            if (filling)
                k = r < 80 ? KIND_PUSH : r < 88 ? KIND_POP : r < 92 ? KIND_PEEK : KIND_SEARCH;
            else
                k = r < 10 ? KIND_PUSH : r < 75 ? KIND_POP : r < 83 ? KIND_PEEK : KIND_SEARCH;
            if (k == KIND_SEARCH && shadow.stored.size() > 0 && $urandom_range(0, 9) < 5)
                v = shadow.stored[$urandom_range(0, shadow.stored.size() - 1)];
            else if (k == KIND_POP || k == KIND_PEEK)
                v = $urandom;
            else
                v = pick_value();
            send_word(k, v);
            if (filling && shadow.stored.size() == DEPTH) begin
                over++;
                if (over >= 8) begin
                    filling = 1'b0;
                    over    = 0;
                end
            end else if (!filling && shadow.stored.size() == 0) begin
                over++;
                if (over >= 5) begin
                    filling = 1'b1;
                    over    = 0;
                end
            end
        end
        i_in_valid <= 1'b0;

        while (shadow.pending.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        $display("run: %0d words (push %0d, pop %0d, peek %0d, search %0d), deepest fill %0d",
                 sent, shadow.n_kind[KIND_PUSH], shadow.n_kind[KIND_POP],
                 shadow.n_kind[KIND_PEEK], shadow.n_kind[KIND_SEARCH], shadow.peak);
        $display("run: %0d full, %0d empty, %0d search hits, %0d search misses, %0d mismatches",
                 shadow.n_full, shadow.n_empty, shadow.n_hit, shadow.n_none, shadow.errors);
        if (shadow.errors == 0 && shadow.pending.size() == 0)
            $display("tb_array_stack_with_search: clean");
        else
            $display("tb_array_stack_with_search: errors");
        $finish;
    end

endmodule
